/* rtl/core/dtcd_pkg.sv */
// Shared types, constants and the month start table for the day count
// to civil date converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtcd_pkg;

  localparam int unsigned DAYS_TO_YEAR0 = 719528;
  localparam int unsigned DAYS_400Y     = 400 * 365 + 100 - 4 + 1;
  localparam int unsigned DAYS_100Y     = 100 * 365 + 25 - 1;
  localparam int unsigned DAYS_4Y       = 4 * 365 + 1;
  localparam int unsigned DAYS_1Y       = 365;
  localparam int unsigned DAYS_LEAP_1Y  = 366;

  // Whole 400-year cycles added so the rebased count is never negative.
  localparam int unsigned CYC_BIAS  = 14695;
  localparam longint unsigned DAY_BIAS =
    longint'(DAYS_TO_YEAR0) + longint'(CYC_BIAS) * longint'(DAYS_400Y);
  localparam int unsigned YEAR_BIAS = 400 * CYC_BIAS;

  // floor(u / 146097) estimated from u[32:12]; low by at most one.
  localparam int unsigned RECIP_400Y_SHIFT = 24;
  localparam longint unsigned RECIP_400Y = (64'd1 << 36) / DAYS_400Y;

  // Exact floor(x / 1461) for x up to one century of days.
  localparam int unsigned RECIP_4Y_SHIFT = 27;
  localparam longint unsigned RECIP_4Y =
    ((64'd1 << RECIP_4Y_SHIFT) + DAYS_4Y - 1) / DAYS_4Y;

  localparam logic [31:0] DAY_COUNT_NA = 32'h8000_0000;
  localparam logic [7:0]  MONTH_NA     = 8'h80;

  typedef struct packed {
    logic        na;    // not-available marker seen
    logic        fin;   // day of year is final, no further split
    logic        leap;  // valid once fin is set
    logic [23:0] year;  // two's complement, accumulated per stage
    logic [17:0] doy;   // day offset within the current span
    logic [4:0]  grp;   // 4-year group index, between two stages
  } dtcd_split_t;

  typedef struct packed {
    logic        na;
    logic        leap;
    logic [23:0] year;
    logic [3:0]  month;
    logic [8:0]  doy;
  } dtcd_mon_t;

  // First day of month idx (0 based, 12 gives the year length).
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = leap ? 9'd60  : 9'd59;
      4'd3:    v = leap ? 9'd91  : 9'd90;
      4'd4:    v = leap ? 9'd121 : 9'd120;
      4'd5:    v = leap ? 9'd152 : 9'd151;
      4'd6:    v = leap ? 9'd182 : 9'd181;
      4'd7:    v = leap ? 9'd213 : 9'd212;
      4'd8:    v = leap ? 9'd244 : 9'd243;
      4'd9:    v = leap ? 9'd274 : 9'd273;
      4'd10:   v = leap ? 9'd305 : 9'd304;
      4'd11:   v = leap ? 9'd335 : 9'd334;
      4'd12:   v = leap ? 9'd366 : 9'd365;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/days_to_civil_date.sv */
// Top level of the day count to civil date converter: three pipeline parts
// in a row. Depends on dtcd_pkg, dtcd_cycle, dtcd_split, dtcd_month.
//
//   channel  dir  beat contents (low bit first)
//   s_axis   in   tdata[31:0] day_count
//   m_axis   out  tdata[23:0] year_out, [31:24] month_out, [36:32] day_out
//
// Pipeline stages: 4 of 400-year division, 4 of century, group and year
// split, 2 of month lookup and output register. One beat per cycle unless stalled.
// Reset clears only the stage valid bits. Under output stall each stage holds
// its beat; empty stages still fill, so input is taken until all ten are full.
`timescale 1ns / 1ps
`default_nettype none

module days_to_civil_date (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // day_count
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // year_out, month_out, day_out, zero pad
);
  import dtcd_pkg::*;

  logic        cyc_valid, cyc_ready, spl_valid, spl_ready;
  dtcd_split_t cyc_out, spl_out;
  logic [23:0] year_w;
  logic [7:0]  month_w;
  logic [4:0]  day_w;

  dtcd_cycle u_cycle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .day_count_i (s_axis_tdata),
    .out_valid_o (cyc_valid),
    .out_ready_i (cyc_ready),
    .out_o       (cyc_out)
  );

  dtcd_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cyc_valid),
    .in_ready_o  (cyc_ready),
    .in_i        (cyc_out),
    .out_valid_o (spl_valid),
    .out_ready_i (spl_ready),
    .out_o       (spl_out)
  );

  dtcd_month u_month (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (spl_valid),
    .in_ready_o  (spl_ready),
    .in_i        (spl_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .year_o      (year_w),
    .month_o     (month_w),
    .day_o       (day_w)
  );

  assign m_axis_tdata = {3'b000, day_w, month_w, year_w};

  a_na_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && month_w == MONTH_NA |-> year_w == '0 && day_w == '0)
    else $error("not-available result has a date");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && month_w != MONTH_NA
      |-> month_w >= 8'd1 && month_w <= 8'd12 && day_w >= 5'd1)
    else $error("date out of range");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

endmodule

`default_nettype wire

/* rtl/core/dtcd_cycle.sv */
// 400-year cycle divider: rebase, reciprocal estimate, remainder, correction.
// Four register stages. Depends on dtcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtcd_cycle (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         day_count_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dtcd_pkg::dtcd_split_t    out_o
);
  import dtcd_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic        na_a_q, na_b_q, na_c_q;
  logic [32:0] u_a_q, u_b_q;
  logic [14:0] q_b_q, q_c_q;
  logic [18:0] r_c_q;

  logic [32:0] u_a_d;
  logic [39:0] est_prod;
  logic [14:0] q_b_d;
  logic [32:0] rem_full;
  logic        ge_p;
  logic [14:0] q_fix;
  dtcd_split_t split_d, split_q;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = split_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // biased count is nonnegative and below 2^33
  assign u_a_d    = {day_count_i[31], day_count_i} + 33'(DAY_BIAS);
  assign est_prod = 40'(u_a_q[32:12]) * 40'(RECIP_400Y);
  assign q_b_d    = est_prod[RECIP_400Y_SHIFT +: 15];
  assign rem_full = u_b_q - 33'(q_b_q) * 33'(DAYS_400Y);

  always_comb begin
    ge_p  = r_c_q >= 19'(DAYS_400Y);
    q_fix = q_c_q + 15'(ge_p);
    split_d.na   = na_c_q;
    split_d.fin  = 1'b0;
    split_d.leap = 1'b0;
    split_d.grp  = '0;
    split_d.year = 24'(q_fix) * 24'(400) - 24'(YEAR_BIAS);
    split_d.doy  = ge_p ? 18'(r_c_q - 19'(DAYS_400Y)) : r_c_q[17:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      na_a_q <= day_count_i == DAY_COUNT_NA;
      u_a_q  <= u_a_d;
    end
    if (rdy[1]) begin
      na_b_q <= na_a_q;
      u_b_q  <= u_a_q;
      q_b_q  <= q_b_d;
    end
    if (rdy[2]) begin
      na_c_q <= na_b_q;
      q_c_q  <= q_b_q;
      r_c_q  <= rem_full[18:0];
    end
    if (rdy[3]) begin
      split_q <= split_d;
    end
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> r_c_q < 19'(2 * DAYS_400Y))
    else $error("400-year estimate off by more than one");

  a_doy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.doy < 18'(DAYS_400Y))
    else $error("day in cycle out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(split_q))
    else $error("cycle stage lost a stalled beat");

endmodule

`default_nettype wire

/* rtl/core/dtcd_split.sv */
// Splits the day within a 400-year cycle into centuries, 4-year groups
// and years, tracking the leap flag. Four register stages. Depends on dtcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtcd_split (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire dtcd_pkg::dtcd_split_t in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output dtcd_pkg::dtcd_split_t      out_o
);
  import dtcd_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  dtcd_split_t e_d, e_q, f_d, f_q, g_d, g_q, h_d, h_q;

  logic [17:0] cen_x;
  logic [1:0]  cen_n;
  logic [15:0] grp_x;
  logic [32:0] grp_prod;
  logic [17:0] yr_x;
  logic [1:0]  yr_n;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // centuries: first century of the cycle carries the extra leap day
  always_comb begin
    e_d   = in_i;
    cen_x = in_i.doy - 18'd1;
    cen_n = 2'(cen_x >= 18'(DAYS_100Y)) + 2'(cen_x >= 18'(2 * DAYS_100Y))
          + 2'(cen_x >= 18'(3 * DAYS_100Y));
    if (in_i.doy >= 18'(DAYS_LEAP_1Y)) begin
      case (cen_n)
        2'd0:    e_d.doy = cen_x;
        2'd1:    e_d.doy = cen_x - 18'(DAYS_100Y);
        2'd2:    e_d.doy = cen_x - 18'(2 * DAYS_100Y);
        2'd3:    e_d.doy = cen_x - 18'(3 * DAYS_100Y);
        default: e_d.doy = cen_x;
      endcase
      e_d.year = in_i.year + 24'(cen_n) * 24'(100);
    end else begin
      e_d.fin  = 1'b1;
      e_d.leap = 1'b1;
    end
  end

  // 4-year groups, quotient by exact reciprocal
  always_comb begin
    f_d      = e_q;
    grp_x    = e_q.doy[15:0] + 16'd1;
    grp_prod = 33'(grp_x) * 33'(RECIP_4Y);
    if (!e_q.fin) begin
      if (e_q.doy < 18'(DAYS_1Y)) begin
        f_d.fin  = 1'b1;
        f_d.leap = 1'b0;
      end else begin
        f_d.doy = 18'(grp_x);
        f_d.grp = grp_prod[RECIP_4Y_SHIFT +: 5];
      end
    end
  end

  always_comb begin
    g_d = f_q;
    if (!f_q.fin) begin
      g_d.doy  = f_q.doy - 18'(f_q.grp) * 18'(DAYS_4Y);
      g_d.year = f_q.year + {17'd0, f_q.grp, 2'b00};
    end
  end

  // single years; the first year of a group is the leap one
  always_comb begin
    h_d  = g_q;
    yr_x = g_q.doy - 18'd1;
    yr_n = 2'(yr_x >= 18'(DAYS_1Y)) + 2'(yr_x >= 18'(2 * DAYS_1Y))
         + 2'(yr_x >= 18'(3 * DAYS_1Y));
    if (!g_q.fin) begin
      h_d.fin = 1'b1;
      if (g_q.doy < 18'(DAYS_LEAP_1Y)) begin
        h_d.leap = 1'b1;
      end else begin
        h_d.leap = 1'b0;
        h_d.year = g_q.year + 24'(yr_n);
        case (yr_n)
          2'd1:    h_d.doy = yr_x - 18'(DAYS_1Y);
          2'd2:    h_d.doy = yr_x - 18'(2 * DAYS_1Y);
          2'd3:    h_d.doy = yr_x - 18'(3 * DAYS_1Y);
          default: h_d.doy = yr_x;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) e_q <= e_d;
    if (rdy[1]) f_q <= f_d;
    if (rdy[2]) g_q <= g_d;
    if (rdy[3]) h_q <= h_d;
  end

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.fin && out_o.doy < 18'(DAYS_LEAP_1Y))
    else $error("year split left a day beyond the year");

  a_short_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.leap |-> out_o.doy < 18'(DAYS_1Y))
    else $error("common year holds day 366");

  a_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && !f_q.fin |-> f_q.grp <= 5'd24)
    else $error("4-year group index out of range");

endmodule

`default_nettype wire

/* rtl/core/dtcd_month.sv */
// Month lookup against the month start table and the output register.
// Two register stages. Depends on dtcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtcd_month (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire dtcd_pkg::dtcd_split_t in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [23:0]                year_o,
  output logic [7:0]                 month_o,
  output logic [4:0]                 day_o
);
  import dtcd_pkg::*;

  localparam int NS = 2;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  dtcd_mon_t   mon_d, mon_q;
  logic [23:0] year_d, year_q;
  logic [7:0]  month_d, month_q;
  logic [4:0]  day_d, day_q;
  logic [8:0]  dom_x;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign year_o      = year_q;
  assign month_o     = month_q;
  assign day_o       = day_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // month = 1 + number of later month starts already reached
  always_comb begin
    mon_d.na    = in_i.na;
    mon_d.leap  = in_i.leap;
    mon_d.year  = in_i.year;
    mon_d.doy   = in_i.doy[8:0];
    mon_d.month = 4'd1;
    for (int j = 1; j < 12; j++) begin
      if (month_start(in_i.leap, 4'(j)) <= in_i.doy[8:0]) begin
        mon_d.month = mon_d.month + 4'd1;
      end
    end
  end

  always_comb begin
    dom_x = mon_q.doy - month_start(mon_q.leap, mon_q.month - 4'd1) + 9'd1;
    if (mon_q.na) begin
      year_d  = '0;
      month_d = MONTH_NA;
      day_d   = '0;
    end else begin
      year_d  = mon_q.year;
      month_d = {4'd0, mon_q.month};
      day_d   = dom_x[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) mon_q <= mon_d;
    if (rdy[1]) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  a_month_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> mon_q.month >= 4'd1 && mon_q.month <= 4'd12)
    else $error("month index out of range");

  a_dom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !mon_q.na |-> dom_x >= 9'd1 && dom_x <= 9'd31)
    else $error("day of month out of range");

  a_na: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && rdy[1] && mon_q.na |=> month_q == MONTH_NA && year_q == '0)
    else $error("not-available beat lost its marker");

endmodule

`default_nettype wire

/* verif/dtcd_date_checker.sv */
// Scoreboard for the day count to civil date converter: predicts the date for
// every accepted day count and compares it with each output beat.
// Depends on dtcd_pkg for the not-available codes.
`timescale 1ns / 1ps

module dtcd_date_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // day_count
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,   // year_out, month_out, day_out, zero pad
  output int               mismatch_count_o,
  output int               dates_pending_o
);

  import dtcd_pkg::*;

  localparam longint EPOCH_OFFSET = 719528;
  localparam longint ERA_DAYS     = 146097;
  localparam longint CENTURY_DAYS = 36524;
  localparam longint QUAD_DAYS    = 1461;

  typedef struct packed {
    logic [23:0] year;
    logic [7:0]  month;
    logic [4:0]  day;
  } civil_date_t;

  civil_date_t dates_pending[$];

  function automatic civil_date_t civil_date_of(input logic [31:0] day_count);
    civil_date_t r;
    longint      d;
    longint      yr;
    longint      era;
    longint      mlen;
    int          mon;
    logic        leap;
    if (day_count == DAY_COUNT_NA) begin
      r.year  = '0;
      r.month = MONTH_NA;
      r.day   = '0;
      return r;
    end
    d = longint'($signed(day_count)) + EPOCH_OFFSET;
    // floor division, the remainder kept non-negative
    era = d / ERA_DAYS;
    d   = d % ERA_DAYS;
    if (d < 0) begin
      d   = d + ERA_DAYS;
      era = era - 1;
    end
    yr = 400 * era;
    // first year of each era and of each non-400 century is special
    if (d >= 366) begin
      yr = yr + 100 * ((d - 1) / CENTURY_DAYS);
      d  = (d - 1) % CENTURY_DAYS;
      if (d >= 365) begin
        yr = yr + 4 * ((d + 1) / QUAD_DAYS);
        d  = (d + 1) % QUAD_DAYS;
        if (d >= 366) begin
          yr = yr + (d - 1) / 365;
          d  = (d - 1) % 365;
        end
      end
    end
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    mon  = 1;
    mlen = 31;
    while (mon < 12 && d >= mlen) begin
      d   = d - mlen;
      mon = mon + 1;
      case (mon)
        2:              mlen = leap ? 29 : 28;
        4, 6, 9, 11:    mlen = 30;
        default:        mlen = 31;
      endcase
    end
    r.year  = yr[23:0];
    r.month = mon[7:0];
    r.day   = d[4:0] + 5'd1;
    return r;
  endfunction

  always @(posedge clk_i) begin
    civil_date_t want;
    civil_date_t got;
    if (rst_ni) begin
      // output side first: a beat leaving now never belongs to one entering now
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tdata[36:32]};
        if (dates_pending.size() == 0) begin
          $error("unexpected output beat: year %0d month %0d day %0d",
                 $signed(got.year), $signed(got.month), got.day);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = dates_pending.pop_front();
          if (got.year !== want.year)
            $error("year_out: expected %0d, got %0d", $signed(want.year), $signed(got.year));
          if (got.month !== want.month)
            $error("month_out: expected %0d, got %0d",
                   $signed(want.month), $signed(got.month));
          if (got.day !== want.day)
            $error("day_out: expected %0d, got %0d", want.day, got.day);
          if (got !== want)
            mismatch_count_o <= mismatch_count_o + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        dates_pending.push_back(civil_date_of(s_axis_tdata));
      dates_pending_o <= dates_pending.size();
    end
  end

endmodule

/* verif/days_to_civil_date_tb.sv */
// Top of the converter testbench: clock, reset, day count stimulus and output
// back-pressure. Depends on days_to_civil_date and dtcd_date_checker.
`timescale 1ns / 1ps

module days_to_civil_date_tb;

  import dtcd_pkg::*;

  localparam int RANDOM_DAYS = 788;
  localparam int BURST_DAYS  = 40;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int   mismatch_count;
  int   dates_pending;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  days_to_civil_date dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dtcd_date_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .dates_pending_o  (dates_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one beat and hold it until taken; returns at the accepting edge.
  task automatic send_day(input logic [31:0] day_count);
    logic rdy;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= day_count;
    forever begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
      if (rdy) break;
    end
  endtask

  // Ends the current burst now and then with an idle gap.
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_day();
    int k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      return $urandom();
    end else if (sel < 65) begin
      return 32'($urandom_range(0, 2000000)) - 32'd1000000;
    end else if (sel < 88) begin
      // near era, century and leap-cycle boundaries
      k = int'($urandom_range(0, 20)) - 10;
      case ($urandom_range(0, 2))
        0:       k = k * 146097;
        1:       k = k * 36524;
        default: k = k * 1461 * int'($urandom_range(1, 25));
      endcase
      return 32'(k - 719528 + int'($urandom_range(0, 4)) - 2);
    end else if (sel < 95) begin
      return $urandom_range(0, 1)
        ? 32'h7FFF_FFFF - 32'($urandom_range(0, 1000))
        : 32'h8000_0001 + 32'($urandom_range(0, 1000));
    end
    return DAY_COUNT_NA;
  endfunction

  // Receiver: stretches of free flow, random stalls and short blocks, plus
  // one long hold-off on request.
  initial begin
    int mode;
    int len;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 30);
        repeat (len) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= 1'b0;
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [31:0] directed_days[$];
    directed_days = '{
      DAY_COUNT_NA,                // not available
      32'h8000_0001, 32'h7FFF_FFFF, // extreme counts
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'(-719528), 32'(-719529),  // year 0 start, year -1 end
      32'd11016, 32'd11322,        // 2000-02-29, 2000-12-31
      32'(-25508), 32'(-25509),    // 1900 around February end
      32'd47541, 32'd47540,        // 2100 around February end
      32'(-573431), 32'(-573432),  // year 400 start, 399 end
      32'(-865625), 32'(-865566),  // year -400 start and its leap day
      32'(-865626), 32'(-684),     // year -401 end, 1968
      32'h5555_5555, 32'hAAAA_AAAA
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_days[i]) begin
      send_day(directed_days[i]);
      sender_gap();
    end

    // drain fully before the pressure phase
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (dates_pending == 0);
    @(posedge clk_i);

    hold_req = 1'b1;
    wait (hold_active);
    repeat (BURST_DAYS) send_day(pick_day());

    burst_left = 0;
    repeat (RANDOM_DAYS) begin
      send_day(pick_day());
      sender_gap();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (dates_pending == 0);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* days_to_civil_date.f */
rtl/core/dtcd_pkg.sv
rtl/core/dtcd_cycle.sv
rtl/core/dtcd_split.sv
rtl/core/dtcd_month.sv
rtl/core/days_to_civil_date.sv
verif/dtcd_date_checker.sv
verif/days_to_civil_date_tb.sv
